@@ sv/assert_macros.svh @@
// Assertion macros shared by the label pixel generator RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled while reset is high.
`define CNL_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("label pixel generator: assertion failed");

// Implication checked in the next cycle, disabled while reset is high.
`define CNL_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("label pixel generator: assertion failed");

`endif

@@ sv/cnl_pkg.sv @@
// Package for the coloured number label pixel generator.
// Holds payload structs, inter-module structs, codes and fixed constants; no dependencies.
package cnl_pkg;

  // Field widths of the item and result.
  localparam int X_W         = 10;
  localparam int Y_W         = 9;
  localparam int GI_W        = 4;
  localparam int GR_W        = 5;
  localparam int FONT_W      = 12;
  localparam int FONT_IDX_W  = $clog2(FONT_W);
  localparam int CH_W        = 8;
  localparam int VAL_W       = 8;

  // Font and label geometry that does not vary.
  localparam int NUM_GLYPHS      = 11;
  localparam logic [GI_W-1:0] DELIM_GLYPH = 4'd10;
  localparam int CHARS_PER_LABEL = 5;
  localparam int LABELS_PER_ROW  = 16;
  localparam int VAL_MAX         = 255;
  localparam int HUNDRED         = 100;
  localparam int TEN             = 10;

  // Character positions inside a label; the outer two are delimiters.
  localparam logic [2:0] POS_HUNDREDS = 3'd1;
  localparam logic [2:0] POS_TENS     = 3'd2;
  localparam logic [2:0] POS_ONES     = 3'd3;

  // Internal widths sized for the full parameter range.
  localparam int FONT_ADDR_W = 10;
  localparam int COL_W       = 5;
  localparam int RECIP_SHIFT = 20;

  // Divider for the red/green blend.
  localparam int DIV_NUM_W = 16;
  localparam int DIV_DEN_W = 8;
  localparam int DIV_QUO_W = 8;

  // Output queue.
  localparam int OUT_FIFO_DEPTH = 32;
  localparam int PTR_W          = $clog2(OUT_FIFO_DEPTH);
  localparam int CREDIT_W       = PTR_W + 1;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;
  localparam logic [CFG_INDEX_W-1:0] CFG_IGNORE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH   = 2'd2;
  localparam logic [8:0] IGNORE_RESET = 9'd2;
  localparam logic [7:0] LOW_RESET    = 8'd50;
  localparam logic [7:0] HIGH_RESET   = 8'd120;

  // Item modes.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  typedef enum logic [1:0] {
    CLS_GREEN,
    CLS_RED,
    CLS_BLEND
  } cls_t;

  typedef struct packed {
    logic              mode;
    logic [GI_W-1:0]   glyph_index;
    logic [GR_W-1:0]   glyph_row;
    logic [FONT_W-1:0] row_bits;
    logic [X_W-1:0]    atlas_x;
    logic [Y_W-1:0]    atlas_y;
  } req_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pix_t;

  typedef struct packed {
    logic                   wr;
    logic                   rd;
    logic [FONT_ADDR_W-1:0] addr;
    logic [FONT_W-1:0]      data;
  } font_req_t;

  typedef struct packed {
    logic             render;
    logic             in_range;
    logic [VAL_W-1:0] value;
    logic [COL_W-1:0] col;
  } loc_info_t;

  typedef struct packed {
    logic visible;
    cls_t cls;
  } div_tag_t;

endpackage

@@ sv/cnl_locate.sv @@
// Address pipeline: atlas position to label value, glyph row address and glyph column.
// Also carries load items to the font store port in order. Uses cnl_pkg.
module cnl_locate #(
  parameter int GLYPH_WIDTH  = 12,
  parameter int GLYPH_HEIGHT = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  cnl_pkg::req_t       item,
  output cnl_pkg::font_req_t  font_req,
  output cnl_pkg::loc_info_t  info
);
  import cnl_pkg::*;

  localparam int SPAN = CHARS_PER_LABEL * GLYPH_WIDTH;
  localparam int XIW  = $clog2(SPAN);
  localparam int CW   = $clog2(GLYPH_WIDTH);
  localparam int RW   = $clog2(GLYPH_HEIGHT);
  localparam int MX   = (1 << RECIP_SHIFT) / SPAN;
  localparam int MY   = (1 << RECIP_SHIFT) / GLYPH_HEIGHT;
  localparam int PXW  = X_W + RECIP_SHIFT;
  localparam int PYW  = Y_W + RECIP_SHIFT;
  localparam int VFW  = Y_W + 5;
  localparam logic [X_W-1:0]         SPAN_X = X_W'(SPAN);
  localparam logic [Y_W-1:0]         GH_Y   = Y_W'(GLYPH_HEIGHT);
  localparam logic [FONT_ADDR_W-1:0] GH_A   = FONT_ADDR_W'(GLYPH_HEIGHT);

  // Stage A: reciprocal estimates of the label column and row.
  logic           a_valid;
  req_t           a_item;
  logic [X_W-1:0] a_qx;
  logic [Y_W-1:0] a_qy;
  logic [PXW-1:0] px;
  logic [PYW-1:0] py;

  // Stage B: remainders and the load address.
  logic                   b_valid;
  logic                   b_mode;
  logic [X_W-1:0]         b_qx;
  logic [X_W-1:0]         b_rx;
  logic [Y_W-1:0]         b_qy;
  logic [Y_W-1:0]         b_ry;
  logic [FONT_ADDR_W-1:0] b_waddr;
  logic                   b_wok;
  logic [FONT_W-1:0]      b_bits;

  // Stage C: corrected quotients, label value.
  logic                   c_valid;
  logic                   c_mode;
  logic [VAL_W-1:0]       c_v;
  logic                   c_inr;
  logic [XIW-1:0]         c_xi;
  logic [RW-1:0]          c_row;
  logic [FONT_ADDR_W-1:0] c_waddr;
  logic                   c_wok;
  logic [FONT_W-1:0]      c_bits;
  logic [X_W-1:0]         lc;
  logic [XIW-1:0]         xi;
  logic [Y_W-1:0]         lr;
  logic [RW-1:0]          row;
  logic [VFW-1:0]         vfull;

  // Stage D: character position, column, hundreds digit.
  logic                   d_valid;
  logic                   d_mode;
  logic [VAL_W-1:0]       d_v;
  logic                   d_inr;
  logic [2:0]             d_pos;
  logic [CW-1:0]          d_col;
  logic [RW-1:0]          d_row;
  logic [1:0]             d_hund;
  logic [6:0]             d_rem;
  logic [FONT_ADDR_W-1:0] d_waddr;
  logic                   d_wok;
  logic [FONT_W-1:0]      d_bits;
  logic [2:0]             pos;
  logic [CW-1:0]          col;
  logic [1:0]             hund;
  logic [6:0]             rem100;

  // Stage E: glyph selected, ready for the font store.
  logic                   e_valid;
  logic                   e_mode;
  logic [VAL_W-1:0]       e_v;
  logic                   e_inr;
  logic [CW-1:0]          e_col;
  logic [RW-1:0]          e_row;
  logic [GI_W-1:0]        e_gl;
  logic [FONT_ADDR_W-1:0] e_waddr;
  logic                   e_wok;
  logic [FONT_W-1:0]      e_bits;
  logic [GI_W-1:0]        tens;
  logic [GI_W-1:0]        ones;
  logic [GI_W-1:0]        gl;

  // The floor reciprocal is at most one short, which stage C repairs.
  assign px = PXW'(item.atlas_x) * PXW'(MX);
  assign py = PYW'(item.atlas_y) * PYW'(MY);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      a_valid <= item_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_item <= item;
    a_qx   <= px[PXW-1:RECIP_SHIFT];
    a_qy   <= py[PYW-1:RECIP_SHIFT];

    b_mode  <= a_item.mode;
    b_qx    <= a_qx;
    b_rx    <= a_item.atlas_x - a_qx * SPAN_X;
    b_qy    <= a_qy;
    b_ry    <= a_item.atlas_y - a_qy * GH_Y;
    b_waddr <= FONT_ADDR_W'(a_item.glyph_index) * GH_A + FONT_ADDR_W'(a_item.glyph_row);
    b_wok   <= (a_item.glyph_index < GI_W'(NUM_GLYPHS)) &&
               (int'(a_item.glyph_row) < GLYPH_HEIGHT);
    b_bits  <= a_item.row_bits;
  end

  always_comb begin
    if (b_rx >= SPAN_X) begin
      lc = b_qx + 1'b1;
      xi = XIW'(b_rx - SPAN_X);
    end else begin
      lc = b_qx;
      xi = XIW'(b_rx);
    end
    if (b_ry >= GH_Y) begin
      lr  = b_qy + 1'b1;
      row = RW'(b_ry - GH_Y);
    end else begin
      lr  = b_qy;
      row = RW'(b_ry);
    end
    vfull = VFW'(lr) * VFW'(LABELS_PER_ROW) + VFW'(lc);
  end

  always_ff @(posedge clk) begin
    c_mode  <= b_mode;
    c_v     <= vfull[VAL_W-1:0];
    c_inr   <= (lc < X_W'(LABELS_PER_ROW)) && (vfull <= VFW'(VAL_MAX));
    c_xi    <= xi;
    c_row   <= row;
    c_waddr <= b_waddr;
    c_wok   <= b_wok;
    c_bits  <= b_bits;
  end

  always_comb begin
    pos = 3'd0;
    col = CW'(c_xi);
    for (int k = 1; k < CHARS_PER_LABEL; k++) begin
      if (c_xi >= XIW'(k * GLYPH_WIDTH)) begin
        pos = 3'(k);
        col = CW'(c_xi - XIW'(k * GLYPH_WIDTH));
      end
    end
    if (c_v >= VAL_W'(2 * HUNDRED)) begin
      hund   = 2'd2;
      rem100 = 7'(c_v - VAL_W'(2 * HUNDRED));
    end else if (c_v >= VAL_W'(HUNDRED)) begin
      hund   = 2'd1;
      rem100 = 7'(c_v - VAL_W'(HUNDRED));
    end else begin
      hund   = 2'd0;
      rem100 = 7'(c_v);
    end
  end

  always_ff @(posedge clk) begin
    d_mode  <= c_mode;
    d_v     <= c_v;
    d_inr   <= c_inr;
    d_pos   <= pos;
    d_col   <= col;
    d_row   <= c_row;
    d_hund  <= hund;
    d_rem   <= rem100;
    d_waddr <= c_waddr;
    d_wok   <= c_wok;
    d_bits  <= c_bits;
  end

  always_comb begin
    tens = '0;
    ones = GI_W'(d_rem);
    for (int k = 1; k < TEN; k++) begin
      if (d_rem >= 7'(k * TEN)) begin
        tens = GI_W'(k);
        ones = GI_W'(d_rem - 7'(k * TEN));
      end
    end
    case (d_pos)
      POS_HUNDREDS: gl = GI_W'(d_hund);
      POS_TENS:     gl = tens;
      POS_ONES:     gl = ones;
      default:      gl = DELIM_GLYPH;
    endcase
  end

  always_ff @(posedge clk) begin
    e_mode  <= d_mode;
    e_v     <= d_v;
    e_inr   <= d_inr;
    e_col   <= d_col;
    e_row   <= d_row;
    e_gl    <= gl;
    e_waddr <= d_waddr;
    e_wok   <= d_wok;
    e_bits  <= d_bits;
  end

  // Loads and renders reach the store from the same stage, so they keep item order.
  always_comb begin
    font_req.wr   = e_valid && (e_mode == MODE_LOAD) && e_wok;
    font_req.rd   = e_valid && (e_mode == MODE_RENDER);
    font_req.addr = font_req.wr ? e_waddr
                                : FONT_ADDR_W'(e_gl) * GH_A + FONT_ADDR_W'(e_row);
    font_req.data = e_bits;
    info.render   = font_req.rd;
    info.in_range = e_inr;
    info.value    = e_v;
    info.col      = COL_W'(e_col);
  end

endmodule

@@ sv/cnl_font_mem.sv @@
// Font store: one synchronous memory of 12-bit glyph rows, one access per cycle.
// Read data is registered. Uses cnl_pkg.
module cnl_font_mem #(
  parameter int GLYPH_HEIGHT = 24
) (
  input  logic                        clk,
  input  cnl_pkg::font_req_t          req,
  output logic [cnl_pkg::FONT_W-1:0]  rdata
);
  import cnl_pkg::*;

  localparam int DEPTH = NUM_GLYPHS * GLYPH_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [FONT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr[AW-1:0]] <= req.data;
    end
    if (req.rd) begin
      rdata <= mem[req.addr[AW-1:0]];
    end
  end

endmodule

@@ sv/cnl_div.sv @@
// Pipelined restoring divider for the colour blend, one quotient bit per stage.
// The numerator must be below the divisor times 256. Uses cnl_pkg.
module cnl_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           op_valid,
  input  logic [cnl_pkg::DIV_NUM_W-1:0]  num,
  input  logic [cnl_pkg::DIV_DEN_W-1:0]  den,
  input  cnl_pkg::div_tag_t              op_tag,
  output logic                           res_valid,
  output logic [cnl_pkg::DIV_QUO_W-1:0]  quo,
  output cnl_pkg::div_tag_t              res_tag
);
  import cnl_pkg::*;

  localparam int QW = DIV_QUO_W;

  logic [QW-1:0]        vld;
  logic [DIV_NUM_W-1:0] rem_r   [QW];
  logic [DIV_DEN_W-1:0] den_r   [QW];
  logic [QW-1:0]        quo_r   [QW];
  div_tag_t             tag_r   [QW];
  logic [DIV_NUM_W-1:0] rem_src [QW];
  logic [DIV_DEN_W-1:0] den_src [QW];
  logic [QW-1:0]        quo_src [QW];
  div_tag_t             tag_src [QW];
  logic [DIV_NUM_W-1:0] sub     [QW];

  always_comb begin
    rem_src[0] = num;
    den_src[0] = den;
    quo_src[0] = '0;
    tag_src[0] = op_tag;
    for (int s = 1; s < QW; s++) begin
      rem_src[s] = rem_r[s-1];
      den_src[s] = den_r[s-1];
      quo_src[s] = quo_r[s-1];
      tag_src[s] = tag_r[s-1];
    end
    for (int s = 0; s < QW; s++) begin
      sub[s] = DIV_NUM_W'(den_src[s]) << (QW - 1 - s);
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QW; s++) begin
      den_r[s] <= den_src[s];
      tag_r[s] <= tag_src[s];
      if (rem_src[s] >= sub[s]) begin
        rem_r[s] <= rem_src[s] - sub[s];
        quo_r[s] <= quo_src[s] | (QW'(1) << (QW - 1 - s));
      end else begin
        rem_r[s] <= rem_src[s];
        quo_r[s] <= quo_src[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QW-2:0], op_valid};
    end
  end

  assign res_valid = vld[QW-1];
  assign quo       = quo_r[QW-1];
  assign res_tag   = tag_r[QW-1];

endmodule

@@ sv/colored_number_label_pixel_gen.sv @@
// Coloured number label pixel generator, top level: uses cnl_pkg and the three submodules.
// Path: a render item passes locate stages A to E, the registered font row and the divider
// to reach the output queue; a load item gives no result and writes the store from stage E.
// Throughput: one item per cycle, set by the pipelined address path, font memory and divider;
// a 32-entry output queue with a credit count stalls input only when 32 renders are pending.
// Reset (synchronous) clears valid bits, queue and credits and restores thresholds; not the font.
`include "assert_macros.svh"

module colored_number_label_pixel_gen #(
  parameter int GLYPH_WIDTH  = 12,
  parameter int GLYPH_HEIGHT = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cnl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cnl_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  cnl_pkg::req_t                     req,
  output logic                              pix_valid,
  input  logic                              pix_stall,
  output cnl_pkg::pix_t                     pix
);
  import cnl_pkg::*;

  localparam logic [CH_W-1:0] CH_FULL = CH_W'(VAL_MAX);

  logic [8:0] ign_thr;
  logic [7:0] low_thr;
  logic [7:0] high_thr;

  logic              req_acc;
  logic              pix_acc;
  logic              render_acc;
  font_req_t         font_req;
  loc_info_t         info;
  logic [FONT_W-1:0] font_row;

  logic                 f_valid;
  loc_info_t            f_info;
  logic                 lit;
  logic [VAL_W-1:0]     diff;
  div_tag_t             tag;
  logic [DIV_NUM_W-1:0] num;
  logic [DIV_DEN_W-1:0] den;

  logic                 d_valid;
  logic [DIV_QUO_W-1:0] d_quo;
  div_tag_t             d_tag;
  pix_t                 pix_new;

  pix_t                fifo_mem [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CREDIT_W-1:0] occ;
  logic [CREDIT_W-1:0] occ_next;
  logic [CREDIT_W-1:0] credit;
  logic [CREDIT_W-1:0] credit_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ign_thr  <= IGNORE_RESET;
      low_thr  <= LOW_RESET;
      high_thr <= HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IGNORE: ign_thr  <= cfg_data;
        CFG_LOW:    low_thr  <= cfg_data[7:0];
        CFG_HIGH:   high_thr <= cfg_data[7:0];
        default:    ;
      endcase
    end
  end

  // Each render item holds a credit from acceptance until its pixel leaves the queue,
  // so the queue can never overflow.
  assign req_stall  = (credit == CREDIT_W'(OUT_FIFO_DEPTH));
  assign req_acc    = req_valid && !req_stall;
  assign render_acc = req_acc && (req.mode == MODE_RENDER);
  assign pix_valid  = (occ != '0);
  assign pix_acc    = pix_valid && !pix_stall;

  cnl_locate #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_locate (
    .clk        (clk),
    .rst        (rst),
    .item_valid (req_acc),
    .item       (req),
    .font_req   (font_req),
    .info       (info)
  );

  cnl_font_mem #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_font_mem (
    .clk   (clk),
    .req   (font_req),
    .rdata (font_row)
  );

  // Side information lined up with the registered font row.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= info.render;
    end
  end

  always_ff @(posedge clk) begin
    f_info <= info;
  end

  always_comb begin
    lit = (f_info.col < COL_W'(FONT_W)) && font_row[f_info.col[FONT_IDX_W-1:0]];
    tag.visible = f_info.in_range && lit && ({1'b0, f_info.value} >= ign_thr);
    if (f_info.value <= low_thr) begin
      tag.cls = CLS_GREEN;
    end else if (f_info.value >= high_thr) begin
      tag.cls = CLS_RED;
    end else begin
      tag.cls = CLS_BLEND;
    end
    // 255 * (v - low), as a shift and a subtract.
    diff = f_info.value - low_thr;
    num  = {diff, 8'd0} - DIV_NUM_W'(diff);
    den  = high_thr - low_thr;
  end

  cnl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (f_valid),
    .num       (num),
    .den       (den),
    .op_tag    (tag),
    .res_valid (d_valid),
    .quo       (d_quo),
    .res_tag   (d_tag)
  );

  always_comb begin
    pix_new = '0;
    if (d_tag.visible) begin
      pix_new.alpha = CH_FULL;
      case (d_tag.cls)
        CLS_GREEN: begin
          pix_new.red   = '0;
          pix_new.green = CH_FULL;
        end
        CLS_RED: begin
          pix_new.red   = CH_FULL;
          pix_new.green = '0;
        end
        CLS_BLEND: begin
          pix_new.red   = d_quo;
          pix_new.green = CH_FULL - d_quo;
        end
        default: begin
          pix_new = '0;
        end
      endcase
    end
  end

  // Output queue.
  always_ff @(posedge clk) begin
    if (d_valid) begin
      fifo_mem[wr_ptr] <= pix_new;
    end
  end

  always_comb begin
    case ({d_valid, pix_acc})
      2'b10:   occ_next = occ + 1'b1;
      2'b01:   occ_next = occ - 1'b1;
      default: occ_next = occ;
    endcase
    case ({render_acc, pix_acc})
      2'b10:   credit_next = credit + 1'b1;
      2'b01:   credit_next = credit - 1'b1;
      default: credit_next = credit;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
      credit <= '0;
    end else begin
      if (d_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pix_acc) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      occ    <= occ_next;
      credit <= credit_next;
    end
  end

  assign pix = fifo_mem[rd_ptr];

  `CNL_ASSERT_IMP(a_credit_cap, clk, rst, 1'b1, credit <= CREDIT_W'(OUT_FIFO_DEPTH))
  `CNL_ASSERT_IMP(a_queue_within_credit, clk, rst, 1'b1, occ <= credit)
  `CNL_ASSERT_IMP(a_no_push_on_full, clk, rst, d_valid, occ != CREDIT_W'(OUT_FIFO_DEPTH) || pix_acc)
  `CNL_ASSERT_NXT(a_render_takes_credit, clk, rst, render_acc && !pix_acc, credit == $past(credit) + 1'b1)
  `CNL_ASSERT_IMP(a_dark_is_blank, clk, rst, pix_valid && pix.alpha == '0, pix.red == '0 && pix.green == '0)

endmodule
